// ===== design/onb_pkg.sv =====
// Package for the Oren-Nayar evaluation core: field widths, register indexes
// and the fixed-point constants. No dependencies.
package onb_pkg;

  localparam int DIR_W      = 16;  // direction component, signed Q1.15
  localparam int VEC_W      = 17;  // component after negation of the ray
  localparam int ALB_W      = 16;  // albedo and A term, unsigned Q0.16
  localparam int COEF_B_W   = 15;  // B term
  localparam int REFL_W     = 16;  // reflectance, unsigned Q2.14
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TERM_W     = 25;  // azimuth term, Q16, capped at 256.0

  localparam logic [ALB_W-1:0]    ALB_RST    = 16'd32768;
  localparam logic [ALB_W-1:0]    COEF_A_RST = 16'd65535;
  localparam logic [COEF_B_W-1:0] COEF_B_RST = 15'd0;

  localparam logic [30:0]       ONE_Q30    = 31'h4000_0000;
  localparam logic [61:0]       ONE_Q60    = 62'h1000_0000_0000_0000;
  localparam logic [TERM_W-1:0] TERM_CAP   = 25'h100_0000;
  localparam logic [26:0]       INV_PI_Q28 = 27'd85445659;
  localparam logic [60:0]       HALF_Q44   = 61'h800_0000_0000;

  typedef logic signed [VEC_W-1:0] vec_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALBEDO_RED   = 3'd0,
    REG_ALBEDO_GREEN = 3'd1,
    REG_ALBEDO_BLUE  = 3'd2,
    REG_COEF_A       = 3'd3,
    REG_COEF_B       = 3'd4
  } cfg_reg_t;

endpackage

// ===== design/onb_if.sv =====
// Channel interfaces of the Oren-Nayar core: query input, result output and
// register write port. Depends on onb_pkg.
interface onb_in_if;
  import onb_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [DIR_W-1:0] normal_x;
  logic signed [DIR_W-1:0] normal_y;
  logic signed [DIR_W-1:0] normal_z;
  logic signed [DIR_W-1:0] ray_x;
  logic signed [DIR_W-1:0] ray_y;
  logic signed [DIR_W-1:0] ray_z;
  logic signed [DIR_W-1:0] light_x;
  logic signed [DIR_W-1:0] light_y;
  logic signed [DIR_W-1:0] light_z;
  modport source (output valid, normal_x, normal_y, normal_z, ray_x, ray_y, ray_z,
                  light_x, light_y, light_z, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, ray_x, ray_y, ray_z,
                light_x, light_y, light_z, output ready);
endinterface

interface onb_out_if;
  import onb_pkg::*;
  logic              valid;
  logic              ready;
  logic [REFL_W-1:0] refl_red;
  logic [REFL_W-1:0] refl_green;
  logic [REFL_W-1:0] refl_blue;
  logic              clipped;
  modport source (output valid, refl_red, refl_green, refl_blue, clipped, input ready);
  modport sink (input valid, refl_red, refl_green, refl_blue, clipped, output ready);
endinterface

interface onb_cfg_if;
  import onb_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/onb_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, floor semantics.
// Carries a sideband word alongside. No package dependency.
module onb_isqrt #(
  parameter int W  = 64,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  logic [W-1:0]    in_x,
  input  logic [SW-1:0]   in_side,
  output logic            out_vld,
  output logic [W/2-1:0]  out_root,
  output logic [SW-1:0]   out_side
);
  localparam int N = W / 2;

  logic [W-1:0]  x_r    [N];
  logic [W-1:0]  root_r [N];
  logic [SW-1:0] side_r [N];
  logic          vld_r  [N];

  logic [W-1:0]  x_cur    [N];
  logic [W-1:0]  root_cur [N];
  logic [W-1:0]  x_nxt    [N];
  logic [W-1:0]  root_nxt [N];

  always_comb begin
    logic [W-1:0] bit_w;
    logic [W-1:0] trial;
    x_cur[0]    = in_x;
    root_cur[0] = '0;
    for (int k = 1; k < N; k++) begin
      x_cur[k]    = x_r[k-1];
      root_cur[k] = root_r[k-1];
    end
    for (int k = 0; k < N; k++) begin
      // trial bit falls by a factor of four each stage
      bit_w = W'(1) << (2 * (N - 1 - k));
      trial = root_cur[k] + bit_w;
      if (x_cur[k] >= trial) begin
        x_nxt[k]    = x_cur[k] - trial;
        root_nxt[k] = (root_cur[k] >> 1) + bit_w;
      end else begin
        x_nxt[k]    = x_cur[k];
        root_nxt[k] = root_cur[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int k = 1; k < N; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      for (int k = 1; k < N; k++) side_r[k] <= side_r[k-1];
      for (int k = 0; k < N; k++) begin
        x_r[k]    <= x_nxt[k];
        root_r[k] <= root_nxt[k];
      end
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_root = root_r[N-1][N-1:0];
  assign out_side = side_r[N-1];
endmodule

// ===== design/onb_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a flag for a
// quotient that does not fit QW bits. No package dependency.
module onb_div #(
  parameter int NW = 62,
  parameter int DW = 32,
  parameter int QW = 32,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [NW-1:0] in_dividend,
  input  logic [DW-1:0] in_divisor,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [QW-1:0] out_quot,
  output logic          out_sat,
  output logic [SW-1:0] out_side
);
  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [CW-1:0] rem_r  [QW+1];
  logic [DW-1:0] dv_r   [QW+1];
  logic [QW-1:0] q_r    [QW+1];
  logic          sat_r  [QW+1];
  logic [SW-1:0] side_r [QW+1];
  logic          vld_r  [QW+1];

  logic [CW-1:0] rem_nxt [QW+1];
  logic [QW-1:0] q_nxt   [QW+1];

  always_comb begin
    logic [CW-1:0] trial;
    rem_nxt[0] = '0;
    q_nxt[0]   = '0;
    for (int j = 1; j <= QW; j++) begin
      trial = CW'(dv_r[j-1]) << (QW - j);
      if (rem_r[j-1] >= trial) begin
        rem_nxt[j] = rem_r[j-1] - trial;
        q_nxt[j]   = q_r[j-1] | (QW'(1) << (QW - j));
      end else begin
        rem_nxt[j] = rem_r[j-1];
        q_nxt[j]   = q_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= QW; j++) vld_r[j] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int j = 1; j <= QW; j++) vld_r[j] <= vld_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= CW'(in_dividend);
      dv_r[0]   <= in_divisor;
      q_r[0]    <= '0;
      sat_r[0]  <= CW'(in_dividend) >= (CW'(in_divisor) << QW);
      side_r[0] <= in_side;
      for (int j = 1; j <= QW; j++) begin
        rem_r[j]  <= rem_nxt[j];
        dv_r[j]   <= dv_r[j-1];
        q_r[j]    <= q_nxt[j];
        sat_r[j]  <= sat_r[j-1];
        side_r[j] <= side_r[j-1];
      end
    end
  end

  assign out_vld  = vld_r[QW];
  assign out_quot = q_r[QW];
  assign out_sat  = sat_r[QW];
  assign out_side = side_r[QW];
endmodule

// ===== design/oren_nayar_brdf_eval_core.sv =====
// Top level of the Oren-Nayar rough-diffuse evaluation core.
// Depends on onb_pkg, onb_if, onb_isqrt and onb_div.
//
//  channel  | dir | handshake      | item
//  ---------+-----+----------------+-------------------------------------------
//  in_item  | in  | valid / ready  | normal, ray, light (9 x signed Q1.15)
//  out_item | out | valid / ready  | refl red/green/blue (Q2.14), clipped
//  cfg_wr   | in  | valid / ready  | register index, 16-bit write data
//
// One item per cycle enters and leaves while the output is not stalled; the
// pipe runs through the two square-root chains (32 and 31 stages) and the two
// divide chains (33 and 26 stages), one bit per stage each.
// Reset is synchronous, active low; it clears valid bits and loads the
// register defaults. A stalled output freezes the whole pipe in place, so no
// item is dropped or repeated; cfg_wr is always ready.
module oren_nayar_brdf_eval_core (
  input logic   clk,
  input logic   rst_n,
  onb_in_if.sink    in_item,
  onb_out_if.source out_item,
  onb_cfg_if.sink   cfg_wr
);
  import onb_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [ALB_W-1:0]    alb_r [3];
  logic [ALB_W-1:0]    coef_a_r;
  logic [COEF_B_W-1:0] coef_b_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 3; c++) alb_r[c] <= ALB_RST;
      coef_a_r <= COEF_A_RST;
      coef_b_r <= COEF_B_RST;
    end else if (cfg_wr.valid) begin
      unique case (cfg_reg_t'(cfg_wr.index))
        REG_ALBEDO_RED:   alb_r[0] <= cfg_wr.data;
        REG_ALBEDO_GREEN: alb_r[1] <= cfg_wr.data;
        REG_ALBEDO_BLUE:  alb_r[2] <= cfg_wr.data;
        REG_COEF_A:       coef_a_r <= cfg_wr.data;
        REG_COEF_B:       coef_b_r <= cfg_wr.data[COEF_B_W-1:0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipe enable: advance every stage whenever the output slot is free or taken
  // ---------------------------------------------------------------------------
  logic out_vld_r;
  logic en;

  assign en            = ~out_vld_r | out_item.ready;
  assign in_item.ready = en;

  // ---------------------------------------------------------------------------
  // S0: capture the query, view = -ray
  // ---------------------------------------------------------------------------
  vec_t n_r [3];
  vec_t v_r [3];
  vec_t l_r [3];
  logic vld0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld0_r <= 1'b0;
    else if (en) vld0_r <= in_item.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0] <= VEC_W'(in_item.normal_x);
      n_r[1] <= VEC_W'(in_item.normal_y);
      n_r[2] <= VEC_W'(in_item.normal_z);
      v_r[0] <= -VEC_W'(in_item.ray_x);
      v_r[1] <= -VEC_W'(in_item.ray_y);
      v_r[2] <= -VEC_W'(in_item.ray_z);
      l_r[0] <= VEC_W'(in_item.light_x);
      l_r[1] <= VEC_W'(in_item.light_y);
      l_r[2] <= VEC_W'(in_item.light_z);
    end
  end

  // ---------------------------------------------------------------------------
  // S1: component products; S2: dot sums and the zero-length check
  // ---------------------------------------------------------------------------
  logic signed [33:0] p_nn_r [3];
  logic signed [33:0] p_vv_r [3];
  logic signed [33:0] p_ll_r [3];
  logic signed [33:0] p_dot_r [3][3];  // [pair][component]: n.v, n.l, v.l
  logic               vld1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld1_r <= 1'b0;
    else if (en) vld1_r <= vld0_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        p_nn_r[k]     <= n_r[k] * n_r[k];
        p_vv_r[k]     <= v_r[k] * v_r[k];
        p_ll_r[k]     <= l_r[k] * l_r[k];
        p_dot_r[0][k] <= n_r[k] * v_r[k];
        p_dot_r[1][k] <= n_r[k] * l_r[k];
        p_dot_r[2][k] <= v_r[k] * l_r[k];
      end
    end
  end

  logic [31:0]        nn_r, nv_r, nl_r;
  logic signed [33:0] dot_r [3];
  logic               zero2_r;
  logic               vld2_r;
  logic signed [33:0] nn_w, nv_w, nl_w;

  assign nn_w = p_nn_r[0] + p_nn_r[1] + p_nn_r[2];
  assign nv_w = p_vv_r[0] + p_vv_r[1] + p_vv_r[2];
  assign nl_w = p_ll_r[0] + p_ll_r[1] + p_ll_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) vld2_r <= 1'b0;
    else if (en) vld2_r <= vld1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nn_r    <= nn_w[31:0];
      nv_r    <= nv_w[31:0];
      nl_r    <= nl_w[31:0];
      zero2_r <= (nn_w == '0) | (nv_w == '0) | (nl_w == '0);
      for (int p = 0; p < 3; p++) dot_r[p] <= p_dot_r[p][0] + p_dot_r[p][1] + p_dot_r[p][2];
    end
  end

  // ---------------------------------------------------------------------------
  // S3: products of squared lengths, dot magnitudes and signs
  // ---------------------------------------------------------------------------
  logic [63:0] lenprod_r [3];
  logic [31:0] mag_r [3];
  logic        sgn_r [3];
  logic        zero3_r;
  logic        vld3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld3_r <= 1'b0;
    else if (en) vld3_r <= vld2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lenprod_r[0] <= nn_r * nv_r;
      lenprod_r[1] <= nn_r * nl_r;
      lenprod_r[2] <= nv_r * nl_r;
      for (int p = 0; p < 3; p++) begin
        sgn_r[p] <= dot_r[p][33];
        mag_r[p] <= dot_r[p][33] ? 32'(-dot_r[p]) : dot_r[p][31:0];
      end
      zero3_r <= zero2_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Length products to norms (sqrt), then cosines as |dot|*2^30 / norm
  // ---------------------------------------------------------------------------
  logic        sq_vld  [3];
  logic [31:0] sq_root [3];
  logic [33:0] sq_side [3];
  logic        dv_vld  [3];
  logic [31:0] dv_quot [3];
  logic        dv_sat  [3];
  logic [1:0]  dv_side [3];

  for (genvar p = 0; p < 3; p++) begin : g_cos
    onb_isqrt #(.W(64), .SW(34)) u_norm (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_vld   (vld3_r),
      .in_x     (lenprod_r[p]),
      .in_side  ({zero3_r, sgn_r[p], mag_r[p]}),
      .out_vld  (sq_vld[p]),
      .out_root (sq_root[p]),
      .out_side (sq_side[p])
    );

    onb_div #(.NW(62), .DW(32), .QW(32), .SW(2)) u_cos (
      .clk         (clk),
      .rst_n       (rst_n),
      .en          (en),
      .in_vld      (sq_vld[p]),
      .in_dividend ({sq_side[p][31:0], 30'd0}),
      .in_divisor  (sq_root[p]),
      .in_side     (sq_side[p][33:32]),
      .out_vld     (dv_vld[p]),
      .out_quot    (dv_quot[p]),
      .out_sat     (dv_sat[p]),
      .out_side    (dv_side[p])
    );
  end

  // ---------------------------------------------------------------------------
  // C: clamp to [-1,1] and apply the sign  (0 = view, 1 = light, 2 = view.light)
  // ---------------------------------------------------------------------------
  logic signed [31:0] cos_r [3];
  logic               zeroc_r;
  logic               vldc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vldc_r <= 1'b0;
    else if (en) vldc_r <= dv_vld[0] & dv_vld[1] & dv_vld[2];
  end

  always_ff @(posedge clk) begin
    logic [31:0] q;
    if (en) begin
      for (int p = 0; p < 3; p++) begin
        q = (dv_sat[p] || dv_quot[p] > 32'(ONE_Q30)) ? 32'(ONE_Q30) : dv_quot[p];
        cos_r[p] <= dv_side[p][0] ? -$signed(q) : $signed(q);
      end
      zeroc_r <= dv_side[0][1] | dv_side[1][1] | dv_side[2][1];
    end
  end

  // ---------------------------------------------------------------------------
  // E: squares for the sines, cross product of cosines, larger |cos|
  // ---------------------------------------------------------------------------
  logic signed [63:0] sqo_w, sqi_w, pci_w;
  logic [30:0]        aco_w, aci_w;
  logic [60:0]        sqo_r, sqi_r;
  logic signed [61:0] pci_r;
  logic signed [31:0] dvl_r;
  logic [30:0]        den_r;
  logic               zeroe_r;
  logic               vlde_r;

  assign sqo_w = cos_r[0] * cos_r[0];
  assign sqi_w = cos_r[1] * cos_r[1];
  assign pci_w = cos_r[0] * cos_r[1];
  assign aco_w = cos_r[0][31] ? 31'(-cos_r[0]) : cos_r[0][30:0];
  assign aci_w = cos_r[1][31] ? 31'(-cos_r[1]) : cos_r[1][30:0];

  always_ff @(posedge clk) begin
    if (!rst_n) vlde_r <= 1'b0;
    else if (en) vlde_r <= vldc_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqo_r   <= sqo_w[60:0];
      sqi_r   <= sqi_w[60:0];
      pci_r   <= pci_w[61:0];
      dvl_r   <= cos_r[2];
      den_r   <= (aco_w > aci_w) ? aco_w : aci_w;
      zeroe_r <= zeroc_r;
    end
  end

  // ---------------------------------------------------------------------------
  // F: sine arguments 1 - cos^2 and the azimuth numerator dvl - co*ci (Q60)
  // ---------------------------------------------------------------------------
  logic [61:0]        argo_r, argi_r;
  logic signed [62:0] num_r;
  logic [30:0]        denf_r;
  logic               zerof_r;
  logic               vldf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vldf_r <= 1'b0;
    else if (en) vldf_r <= vlde_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      argo_r  <= ONE_Q60 - {1'b0, sqo_r};
      argi_r  <= ONE_Q60 - {1'b0, sqi_r};
      num_r   <= $signed({dvl_r[31], dvl_r, 30'd0}) - $signed({pci_r[61], pci_r});
      denf_r  <= den_r;
      zerof_r <= zeroe_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Sines of view and light angles
  // ---------------------------------------------------------------------------
  logic        so_vld, si_vld;
  logic [30:0] so_root, si_root;
  logic [63:0] so_side;
  logic [30:0] si_side;

  onb_isqrt #(.W(62), .SW(64)) u_sin_o (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vldf_r),
    .in_x     (argo_r),
    .in_side  ({zerof_r, num_r}),
    .out_vld  (so_vld),
    .out_root (so_root),
    .out_side (so_side)
  );

  onb_isqrt #(.W(62), .SW(31)) u_sin_i (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vldf_r),
    .in_x     (argi_r),
    .in_side  (denf_r),
    .out_vld  (si_vld),
    .out_root (si_root),
    .out_side (si_side)
  );

  // ---------------------------------------------------------------------------
  // Azimuth term: numerator / (larger |cos| * 2^14), kept only where both sines
  // are nonzero and the numerator is positive; a zero divisor saturates to cap
  // ---------------------------------------------------------------------------
  logic              term_use_w;
  logic              tq_vld, tq_sat;
  logic [TERM_W-1:0] tq_quot;
  logic [1:0]        tq_side;

  assign term_use_w = (so_root != '0) & (si_root != '0) & ~so_side[62] & (so_side[62:0] != '0);

  onb_div #(.NW(62), .DW(45), .QW(TERM_W), .SW(2)) u_term (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_vld      (so_vld & si_vld),
    .in_dividend (so_side[61:0]),
    .in_divisor  ({si_side, 14'd0}),
    .in_side     ({so_side[63], term_use_w}),
    .out_vld     (tq_vld),
    .out_quot    (tq_quot),
    .out_sat     (tq_sat),
    .out_side    (tq_side)
  );

  // T: cap the term at 256.0
  logic [TERM_W-1:0] term_r;
  logic              zerot_r;
  logic              vldt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vldt_r <= 1'b0;
    else if (en) vldt_r <= tq_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!tq_side[0]) term_r <= '0;
      else if (tq_sat || tq_quot > TERM_CAP) term_r <= TERM_CAP;
      else term_r <= tq_quot;
      zerot_r <= tq_side[1];
    end
  end

  // ---------------------------------------------------------------------------
  // M1: B*term; M2: val = A + B*term (Q32)
  // ---------------------------------------------------------------------------
  logic [39:0] bt_r, val_r;
  logic        zero_m1_r, zero_m2_r;
  logic        vld_m1_r, vld_m2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_m1_r <= 1'b0;
      vld_m2_r <= 1'b0;
    end else if (en) begin
      vld_m1_r <= vldt_r;
      vld_m2_r <= vld_m1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bt_r      <= coef_b_r * term_r;
      zero_m1_r <= zerot_r;
      val_r     <= {8'd0, coef_a_r, 16'd0} + bt_r;
      zero_m2_r <= zero_m1_r;
    end
  end

  // ---------------------------------------------------------------------------
  // M3: albedo * val in two partial products per channel
  // M4: reassemble, y = x >> 18, flag y >= 2^34
  // M5: y / pi in two partial products
  // ---------------------------------------------------------------------------
  logic [39:0] plo_r [3];
  logic [31:0] phi_r [3];
  logic [33:0] y_r   [3];
  logic        big4_r [3];
  logic [43:0] ql_r  [3];
  logic [43:0] qh_r  [3];
  logic        big5_r [3];
  logic        zero_m3_r, zero_m4_r, zero_m5_r;
  logic        vld_m3_r, vld_m4_r, vld_m5_r;
  logic [55:0] x_w [3];

  always_comb begin
    for (int c = 0; c < 3; c++) x_w[c] = {16'd0, plo_r[c]} + {phi_r[c], 24'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_m3_r <= 1'b0;
      vld_m4_r <= 1'b0;
      vld_m5_r <= 1'b0;
    end else if (en) begin
      vld_m3_r <= vld_m2_r;
      vld_m4_r <= vld_m3_r;
      vld_m5_r <= vld_m4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        plo_r[c]  <= alb_r[c] * val_r[23:0];
        phi_r[c]  <= alb_r[c] * val_r[39:24];
        y_r[c]    <= x_w[c][51:18];
        big4_r[c] <= |x_w[c][55:52];
        ql_r[c]   <= y_r[c][16:0] * INV_PI_Q28;
        qh_r[c]   <= y_r[c][33:17] * INV_PI_Q28;
        big5_r[c] <= big4_r[c];
      end
      zero_m3_r <= zero_m2_r;
      zero_m4_r <= zero_m3_r;
      zero_m5_r <= zero_m4_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: round half up to Q2.14, saturate, flag the clip
  // ---------------------------------------------------------------------------
  logic [REFL_W-1:0] refl_r [3];
  logic              clip_r;
  logic [60:0]       s_w   [3];
  logic [2:0]        sat_w;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      s_w[c]   = {qh_r[c], 17'd0} + {17'd0, ql_r[c]} + HALF_Q44;
      sat_w[c] = big5_r[c] | s_w[c][60];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= vld_m5_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        if (zero_m5_r) refl_r[c] <= '0;
        else if (sat_w[c]) refl_r[c] <= '1;
        else refl_r[c] <= s_w[c][59:44];
      end
      clip_r <= ~zero_m5_r & (|sat_w);
    end
  end

  assign out_item.valid      = out_vld_r;
  assign out_item.refl_red   = refl_r[0];
  assign out_item.refl_green = refl_r[1];
  assign out_item.refl_blue  = refl_r[2];
  assign out_item.clipped    = clip_r;
endmodule
